[src/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants for the voxel face culler: field widths,
// operation and direction codes, and the face record.
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int EDGE_LEN_DEF = 16;
    localparam int POS_W        = 4;
    localparam int TYPE_W       = 8;
    localparam int DIR_W        = 3;
    localparam int NUM_DIRS     = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NX = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [DIR_W-1:0]  direction;
        logic [TYPE_W-1:0] face_type;
        logic              last_face;
    } face_t;

endpackage

[src/vfc_ram.sv]
// ----------------------------------------------------------------------------
// vfc_ram
// Generic simple dual-port RAM with one write port and one registered
// read port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/vfc_ctrl.sv]
// ----------------------------------------------------------------------------
// vfc_ctrl
// Request sequencer. In-range writes go straight to the voxel store. A query
// reads the block and, if not air, its six neighbors one per cycle, collects
// the exposed directions in a mask and hands the faces out in direction order.
// ----------------------------------------------------------------------------
module vfc_ctrl
    import vfc_pkg::*;
#(
    parameter int EDGE_LEN = EDGE_LEN_DEF,
    parameter int CW       = $clog2(EDGE_LEN),
    parameter int AW       = 3 * CW
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [POS_W-1:0]  s_pos_x,
    input  logic [POS_W-1:0]  s_pos_y,
    input  logic [POS_W-1:0]  s_pos_z,
    input  logic [TYPE_W-1:0] s_new_type,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [TYPE_W-1:0] ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  logic [TYPE_W-1:0] ram_rdata,
    output logic              face_valid,
    input  logic              face_ready,
    output face_t             face
);

    localparam int LastIdx = EDGE_LEN - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TYPE,
        ST_GATHER,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     x_reg, x_next;
    logic [POS_W-1:0]     y_reg, y_next;
    logic [POS_W-1:0]     z_reg, z_next;
    logic [TYPE_W-1:0]    btype_reg, btype_next;
    logic [DIR_W-1:0]     dir_reg, dir_next;
    logic [NUM_DIRS-1:0]  mask_reg, mask_next;

    logic                 in_range;
    logic [AW-1:0]        in_addr;
    logic [DIR_W-1:0]     sel_dir;
    logic [NUM_DIRS-1:0]  mask_rest;

    function automatic logic [AW-1:0] nbr_addr(input logic [DIR_W-1:0] dir,
                                               input logic [POS_W-1:0] px,
                                               input logic [POS_W-1:0] py,
                                               input logic [POS_W-1:0] pz);
        logic [CW-1:0] xc;
        logic [CW-1:0] yc;
        logic [CW-1:0] zc;
        xc = CW'(px);
        yc = CW'(py);
        zc = CW'(pz);
        case (dir)
            DIR_PX:  xc = xc + CW'(1);
            DIR_NX:  xc = xc - CW'(1);
            DIR_PY:  yc = yc + CW'(1);
            DIR_NY:  yc = yc - CW'(1);
            DIR_PZ:  zc = zc + CW'(1);
            default: zc = zc - CW'(1);
        endcase
        return {zc, yc, xc};
    endfunction

    function automatic logic at_border(input logic [DIR_W-1:0] dir,
                                       input logic [POS_W-1:0] px,
                                       input logic [POS_W-1:0] py,
                                       input logic [POS_W-1:0] pz);
        logic b;
        case (dir)
            DIR_PX:  b = (int'(px) >= LastIdx);
            DIR_NX:  b = (px == '0);
            DIR_PY:  b = (int'(py) >= LastIdx);
            DIR_NY:  b = (py == '0);
            DIR_PZ:  b = (int'(pz) >= LastIdx);
            DIR_NZ:  b = (pz == '0);
            default: b = 1'b1;
        endcase
        return b;
    endfunction

    assign in_range = (int'(s_pos_x) < EDGE_LEN) && (int'(s_pos_y) < EDGE_LEN)
                   && (int'(s_pos_z) < EDGE_LEN);
    assign in_addr  = {CW'(s_pos_z), CW'(s_pos_y), CW'(s_pos_x)};

    always_comb begin
        sel_dir = DIR_PX;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_dir = DIR_W'(i);
            end
        end
        mask_rest          = mask_reg;
        mask_rest[sel_dir] = 1'b0;
    end

    assign face.x         = x_reg;
    assign face.y         = y_reg;
    assign face.z         = z_reg;
    assign face.direction = sel_dir;
    assign face.face_type = btype_reg;
    assign face.last_face = (mask_rest == '0);

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        btype_next = btype_reg;
        dir_next   = dir_reg;
        mask_next  = mask_reg;
        s_ready    = 1'b0;
        face_valid = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = in_addr;
        ram_wdata  = s_new_type;
        ram_raddr  = in_addr;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    x_next = s_pos_x;
                    y_next = s_pos_y;
                    z_next = s_pos_z;
                    if (in_range) begin
                        if (s_operation == OP_WRITE) begin
                            ram_we = 1'b1;
                        end else begin
                            state_next = ST_TYPE;
                        end
                    end
                end
            end
            ST_TYPE: begin
                ram_raddr = nbr_addr(DIR_PX, x_reg, y_reg, z_reg);
                if (ram_rdata == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    btype_next = ram_rdata;
                    dir_next   = DIR_PX;
                    mask_next  = '0;
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                ram_raddr = nbr_addr(dir_reg + DIR_W'(1), x_reg, y_reg, z_reg);
                mask_next[dir_reg] = at_border(dir_reg, x_reg, y_reg, z_reg)
                                  || (ram_rdata == '0);
                if (dir_reg == DIR_NZ) begin
                    state_next = ST_EMIT;
                end else begin
                    dir_next = dir_reg + DIR_W'(1);
                end
            end
            ST_EMIT: begin
                face_valid = (mask_reg != '0);
                if (mask_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (face_ready) begin
                    mask_next = mask_rest;
                    if (mask_rest == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mask_reg  <= '0;
            dir_reg   <= DIR_PX;
        end else begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            dir_reg   <= dir_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        btype_reg <= btype_next;
    end

endmodule

[src/voxel_face_culler.sv]
// ----------------------------------------------------------------------------
// voxel_face_culler
// Exposed-face finder for one cubic chunk of block types.
//
// Requests arrive on the s_ channel (valid/ready). A write request stores
// s_new_type at (s_pos_x, s_pos_y, s_pos_z). A query request reads the
// block and then its six neighbors from the voxel store, one read per
// cycle on the single read port. It ends after the block read if the block
// is air, and otherwise holds the input until all its exposed faces, if
// any, are handed on. Faces leave on the m_ channel in the order +x, -x,
// +y, -y, +z, -z, with m_last_face on the final one; the first face is
// valid once all six neighbors are read. Requests with a coordinate outside
// the chunk are dropped. The faces pass through an output register. While
// m_ready is low and a face waits there, the sequencer holds the next face
// and the input stays blocked, so each stalled cycle lengthens the query.
// Reset clears the control state; the store contents stay undefined until
// written, and every block must be written before it or its neighbors are
// queried.
// ----------------------------------------------------------------------------
module voxel_face_culler
    import vfc_pkg::*;
#(
    parameter int EDGE_LEN = EDGE_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [POS_W-1:0]  s_pos_x,
    input  logic [POS_W-1:0]  s_pos_y,
    input  logic [POS_W-1:0]  s_pos_z,
    input  logic [TYPE_W-1:0] s_new_type,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_face_x,
    output logic [POS_W-1:0]  m_face_y,
    output logic [POS_W-1:0]  m_face_z,
    output logic [DIR_W-1:0]  m_direction,
    output logic [TYPE_W-1:0] m_face_type,
    output logic              m_last_face
);

    localparam int CW    = $clog2(EDGE_LEN);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [TYPE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [TYPE_W-1:0] ram_rdata;

    logic              face_valid;
    logic              face_ready;
    face_t             face;

    logic              m_valid_reg, m_valid_next;
    face_t             out_reg, out_next;

    vfc_ram #(
        .WIDTH (TYPE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vfc_ctrl #(
        .EDGE_LEN (EDGE_LEN),
        .CW       (CW),
        .AW       (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_new_type  (s_new_type),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .face_valid  (face_valid),
        .face_ready  (face_ready),
        .face        (face)
    );

    assign face_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (face_valid && face_ready) begin
            m_valid_next = 1'b1;
            out_next     = face;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_face_x    = out_reg.x;
    assign m_face_y    = out_reg.y;
    assign m_face_z    = out_reg.z;
    assign m_direction = out_reg.direction;
    assign m_face_type = out_reg.face_type;
    assign m_last_face = out_reg.last_face;

endmodule
